@@ sv/cs_pkg.sv @@
// Shared types and constants for the cosine similarity block.
`default_nettype none

package cs_pkg;

    // Element, accumulator and datapath widths
    localparam int ELEM_W   = 16;
    localparam int SUM_W    = 48;
    localparam int LIMB_W   = 24;
    localparam int PROD_W   = 2 * SUM_W;
    localparam int QUOT_W   = 30;
    localparam int ROOT_W   = QUOT_W / 2;
    localparam int CNT_W    = 5;

    // Result scale, one in Q1.14
    localparam logic [ELEM_W-1:0] ONE_Q14 = 16'd16384;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_ACC  = 8'b0000_0001,
        ST_CHK  = 8'b0000_0010,
        ST_MULP = 8'b0000_0100,
        ST_MULN = 8'b0000_1000,
        ST_CMP  = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_ROOT = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

@@ sv/cosine_similarity.sv @@
// Cosine similarity of two streamed Q4.11 vectors, result in Q1.14.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  s_*     | in        | s_tvalid/s_tready | s_tdata {b_value, a_value}, s_tlast last_item
//  m_*     | out       | m_tvalid/m_tready | m_tdata similarity, m_tuser zero_norm
//
// Element pairs are summed at one item per cycle while ready (three 16x16 products).
// After the item marked last is taken, its result is worked out in order:
// one check, 8 steps of the shared 24x24 multiplier, one compare, 30 restoring
// divide steps, 15 square root steps and the load; s_tready is low meanwhile.
// When dot^2 reaches the norm product the divide is skipped, and a zero norm needs
// only the check and the load. A result still waiting in the output register
// holds the load, and s_tready, back further.
// The result sits in an output register, so items are taken while it waits.
// rst_n clears the sums, the sequencer and the output valid asynchronously.
`default_nettype none

module cosine_similarity (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] a_value, [31:16] b_value
    input  wire logic        s_tlast,   // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] similarity
    output logic             m_tuser    // [0] zero_norm
);

    cs_pkg::state_t state_reg, state_next;

    logic [cs_pkg::SUM_W-1:0]  dot_reg, dot_next;
    logic [cs_pkg::SUM_W-1:0]  na_reg, na_next;
    logic [cs_pkg::SUM_W-1:0]  nb_reg, nb_next;
    logic [cs_pkg::PROD_W-1:0] p_reg, p_next;
    logic [cs_pkg::PROD_W-1:0] n_reg, n_next;
    logic [cs_pkg::QUOT_W-1:0] q_reg, q_next;
    logic [cs_pkg::QUOT_W-1:0] root_reg, root_next;
    logic [cs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                      zn_reg, zn_next;
    logic                      mvalid_reg, mvalid_next;
    logic [cs_pkg::ELEM_W-1:0] mdata_reg, mdata_next;
    logic                      muser_reg, muser_next;

    logic signed [cs_pkg::ELEM_W-1:0]   a_val, b_val;
    logic signed [2*cs_pkg::ELEM_W-1:0] ab_prod, aa_prod, bb_prod;
    logic                               take;

    logic [cs_pkg::SUM_W-1:0]   mag;
    logic                       neg;
    logic [cs_pkg::SUM_W-1:0]   mx, my;
    logic [cs_pkg::LIMB_W-1:0]  xl, yl;
    logic [cs_pkg::SUM_W-1:0]   pp;
    logic [1:0]                 pp_pos;
    logic [cs_pkg::PROD_W-1:0]  pp_ext;

    logic [cs_pkg::PROD_W+1:0]  div_diff;
    logic                       div_ge;

    logic [cs_pkg::QUOT_W-1:0]  one_bit;
    logic [cs_pkg::QUOT_W:0]    trial;
    logic                       root_ge;

    logic [cs_pkg::ELEM_W-1:0]  rmag;
    logic                       out_free;

    // Input side
    assign a_val    = $signed(s_tdata[15:0]);
    assign b_val    = $signed(s_tdata[31:16]);
    assign ab_prod  = a_val * b_val;
    assign aa_prod  = a_val * a_val;
    assign bb_prod  = b_val * b_val;
    assign s_tready = (state_reg == cs_pkg::ST_ACC);
    assign take     = s_tvalid && s_tready;

    // Dot product magnitude and sign
    assign neg = dot_reg[cs_pkg::SUM_W-1];
    assign mag = neg ? (~dot_reg + 48'd1) : dot_reg;

    // Shared 24x24 multiplier, limb pair picked by the step counter
    assign mx     = (state_reg == cs_pkg::ST_MULP) ? mag : na_reg;
    assign my     = (state_reg == cs_pkg::ST_MULP) ? mag : nb_reg;
    assign xl     = cnt_reg[1] ? mx[47:24] : mx[23:0];
    assign yl     = cnt_reg[0] ? my[47:24] : my[23:0];
    assign pp     = xl * yl;
    assign pp_pos = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};

    always_comb
    begin
        unique case (pp_pos)
            2'd1:    pp_ext = {24'd0, pp, 24'd0};
            2'd2:    pp_ext = {pp, 48'd0};
            default: pp_ext = {48'd0, pp};
        endcase
    end

    // Restoring divide step: remainder doubled against the norm product
    assign div_diff = {1'b0, p_reg, 1'b0} - {2'b00, n_reg};
    assign div_ge   = !div_diff[cs_pkg::PROD_W+1];

    // Square root step, one result bit per cycle
    assign one_bit = cs_pkg::QUOT_W'(1) << {cnt_reg[3:0], 1'b0};
    assign trial   = {1'b0, root_reg} + {1'b0, one_bit};
    assign root_ge = ({1'b0, q_reg} >= trial);

    // Rounded magnitude: largest r with (2r-1)^2 <= quotient
    assign rmag     = cs_pkg::ELEM_W'(({1'b0, root_reg[cs_pkg::ROOT_W-1:0]} + 16'd1) >> 1);
    assign out_free = !mvalid_reg || m_tready;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next  = state_reg;
        dot_next    = dot_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        zn_next     = zn_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;

        unique case (state_reg)
            cs_pkg::ST_ACC:
            begin
                if (take)
                begin
                    dot_next = dot_reg + {{16{ab_prod[31]}}, ab_prod};
                    na_next  = na_reg + {16'd0, aa_prod};
                    nb_next  = nb_reg + {16'd0, bb_prod};
                    if (s_tlast)
                    begin
                        state_next = cs_pkg::ST_CHK;
                    end
                end
            end
            cs_pkg::ST_CHK:
            begin
                cnt_next = '0;
                p_next   = '0;
                n_next   = '0;
                if (na_reg == '0 || nb_reg == '0)
                begin
                    zn_next    = 1'b1;
                    root_next  = '0;
                    state_next = cs_pkg::ST_FIN;
                end
                else
                begin
                    zn_next    = 1'b0;
                    state_next = cs_pkg::ST_MULP;
                end
            end
            cs_pkg::ST_MULP:
            begin
                p_next   = p_reg + pp_ext;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = cs_pkg::ST_MULN;
                end
            end
            cs_pkg::ST_MULN:
            begin
                n_next   = n_reg + pp_ext;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = cs_pkg::ST_CMP;
                end
            end
            cs_pkg::ST_CMP:
            begin
                // dot^2 >= norm product: quotient saturates, result is plus or minus one
                if (p_reg >= n_reg)
                begin
                    q_next     = '1;
                    root_next  = '0;
                    cnt_next   = 5'(cs_pkg::ROOT_W - 1);
                    state_next = cs_pkg::ST_ROOT;
                end
                else
                begin
                    q_next     = '0;
                    cnt_next   = 5'(cs_pkg::QUOT_W - 1);
                    state_next = cs_pkg::ST_DIV;
                end
            end
            cs_pkg::ST_DIV:
            begin
                p_next   = div_ge ? div_diff[cs_pkg::PROD_W-1:0]
                                  : {p_reg[cs_pkg::PROD_W-2:0], 1'b0};
                q_next   = {q_reg[cs_pkg::QUOT_W-2:0], div_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    root_next  = '0;
                    cnt_next   = 5'(cs_pkg::ROOT_W - 1);
                    state_next = cs_pkg::ST_ROOT;
                end
            end
            cs_pkg::ST_ROOT:
            begin
                if (root_ge)
                begin
                    q_next    = q_reg - trial[cs_pkg::QUOT_W-1:0];
                    root_next = (root_reg >> 1) + one_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = cs_pkg::ST_FIN;
                end
            end
            cs_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = neg ? (~rmag + 16'd1) : rmag;
                    muser_next  = zn_reg;
                    dot_next    = '0;
                    na_next     = '0;
                    nb_next     = '0;
                    state_next  = cs_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = cs_pkg::ST_ACC;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cs_pkg::ST_ACC;
            dot_reg    <= '0;
            na_reg     <= '0;
            nb_reg     <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dot_reg    <= dot_next;
            na_reg     <= na_next;
            nb_reg     <= nb_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        n_reg     <= n_next;
        q_reg     <= q_next;
        root_reg  <= root_next;
        zn_reg    <= zn_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // Result stays within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= $signed(cs_pkg::ONE_Q14))
                  && ($signed(m_tdata) >= -$signed(cs_pkg::ONE_Q14)))
        else $error("similarity out of range");

    // Zero norm gives a zero similarity
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("zero norm with non-zero similarity");

    // Last item stops intake while the result is worked out
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("item taken during final computation");

    // Sums are cleared once the result is loaded
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cs_pkg::ST_FIN && out_free) |=>
            (dot_reg == '0 && na_reg == '0 && nb_reg == '0))
        else $error("sums not cleared after result");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the streamed cosine similarity block.
`timescale 1ns / 100ps

module testbench;

    // Result item as it leaves the block
    typedef struct packed {
        logic [15:0] sim;
        logic        zero_norm;
    } cos_result_t;

    // One row of the directed stimulus; want is used only where known is set
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        last;
        logic        known;
        cos_result_t want;
    } pair_row_t;

    localparam int          FULL_PAIRS   = 64;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          DIR_ROWS     = 24;
    localparam logic [15:0] POS_ONE      = 16'h4000;
    localparam logic [15:0] NEG_ONE      = 16'hC000;
    localparam logic [15:0] MOST_NEG     = 16'h8000;
    localparam logic [15:0] MOST_POS     = 16'h7FFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [15:0] a_value, [31:16] b_value
    logic        s_tlast = 1'b0;   // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] similarity
    logic        m_tuser;          // [0] zero_norm

    // Predictor sums, cleared on every last item
    logic [47:0] dot_acc = '0;
    logic [47:0] norm_a_acc = '0;
    logic [47:0] norm_b_acc = '0;

    cos_result_t similarity_due [$];
    cos_result_t got_due;
    pair_row_t   dir_rows [DIR_ROWS];

    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold = 0;
    int items_sent = 0;
    int results_seen = 0;
    int zero_norm_seen = 0;
    int full_scale_seen = 0;
    int errors = 0;
    int random_start;

    cosine_similarity dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Element value: extremes, small values near zero, or anything
    function automatic logic [15:0] pick_elem();
        int          r;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 4))
                0:       v = MOST_NEG;
                1:       v = MOST_POS;
                2:       v = 16'h0000;
                3:       v = 16'hFFFF;
                default: v = 16'h0001;
            endcase
        end
        else if (r < 35)
        begin
            v = 16'($urandom_range(0, 32));
            v = v - 16'd16;
        end
        else
            v = 16'($urandom);
        return v;
    endfunction

    // Fold one pair into the sums; on the last pair work out the rounded cosine
    function automatic bit accumulate_pair(input logic [15:0] a, input logic [15:0] b,
                                           input logic last, output cos_result_t res);
        logic signed [31:0] p_ab;
        logic signed [31:0] p_aa;
        logic signed [31:0] p_bb;
        logic [48:0]        mag;
        logic [127:0]       rhs;
        logic [127:0]       norms;
        logic [127:0]       odd;
        logic [127:0]       lhs;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic [15:0]        mag16;
        bit                 neg;
        p_ab = $signed(a) * $signed(b);
        p_aa = $signed(a) * $signed(a);
        p_bb = $signed(b) * $signed(b);
        dot_acc    = dot_acc + {{16{p_ab[31]}}, p_ab};
        norm_a_acc = norm_a_acc + {16'b0, p_aa};
        norm_b_acc = norm_b_acc + {16'b0, p_bb};
        res = '0;
        if (!last)
            return 1'b0;
        if (norm_a_acc == '0 || norm_b_acc == '0)
            res.zero_norm = 1'b1;
        else
        begin
            // largest r with (2r-1)^2 * nA * nB <= dot^2 * 2^30, r up to one
            neg = dot_acc[47];
            mag = neg ? 49'h1_0000_0000_0000 - {1'b0, dot_acc} : {1'b0, dot_acc};
            rhs = {79'b0, mag};
            rhs = (rhs * rhs) << 30;
            norms = {80'b0, norm_a_acc};
            lhs = {80'b0, norm_b_acc};
            norms = norms * lhs;
            lo = 0;
            hi = 16384;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                odd = 2 * mid - 1;
                lhs = odd * odd * norms;
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            mag16 = lo[15:0];
            res.sim = neg ? 16'h0000 - mag16 : mag16;
        end
        dot_acc    = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
        return 1'b1;
    endfunction

    // Offer one pair at a falling edge, wait for it to be taken, record what is due
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                             input logic known, input cos_result_t want);
        int          gap;
        cos_result_t due;
        gap = tx_gaps_on ? pick_idle() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (accumulate_pair(a, b, last, due))
            similarity_due.push_back(known ? want : due);
        items_sent++;
        @(negedge clk);
    endtask

    // One random vector pair of the given length and shape
    task automatic send_vector(input int len, input int shape);
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < len; i++)
        begin
            a = pick_elem();
            case (shape)
                0:       b = pick_elem();
                1:       b = a;
                2:       b = 16'h0000 - a;
                3:       begin a = 16'h0000; b = pick_elem(); end
                4:       b = 16'h0000;
                default: b = a + 16'($urandom_range(0, 6)) - 16'd3;
            endcase
            send_pair(a, b, i == len - 1, 1'b0, '0);
        end
    endtask

    // Receiver: ready in short runs, stalls of random length when enabled
    always @(negedge clk)
    begin
        if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
        else if (rx_stalls_on && m_tready)
        begin
            m_tready <= 1'b0;
            rx_hold  <= pick_idle();
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold  <= $urandom_range(0, 6);
        end
    end

    // Compare every result item with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (similarity_due.size() == 0)
            begin
                $display("%0t: result with none due: similarity %0d zero_norm %0b",
                         $time, $signed(m_tdata), m_tuser);
                errors++;
            end
            else
            begin
                got_due = similarity_due.pop_front();
                if (m_tdata !== got_due.sim)
                begin
                    $display("%0t: similarity expected %0d got %0d", $time,
                             $signed(got_due.sim), $signed(m_tdata));
                    errors++;
                end
                if (m_tuser !== got_due.zero_norm)
                begin
                    $display("%0t: zero_norm expected %0b got %0b", $time,
                             got_due.zero_norm, m_tuser);
                    errors++;
                end
                if (got_due.zero_norm)
                    zero_norm_seen++;
                if (got_due.sim == POS_ONE || got_due.sim == NEG_ONE)
                    full_scale_seen++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int len;
        int r;
        logic [15:0] ext_a;
        logic [15:0] ext_b;

        // a, b, last, known, {similarity, zero_norm}
        dir_rows = '{
            {16'h0000,    16'h0000,    1'b1, 1'b1, 16'h0000, 1'b1},  // empty sums after reset
            {MOST_NEG,    MOST_NEG,    1'b1, 1'b1, POS_ONE,  1'b0},
            {MOST_NEG,    MOST_POS,    1'b1, 1'b1, NEG_ONE,  1'b0},
            {MOST_POS,    MOST_POS,    1'b1, 1'b1, POS_ONE,  1'b0},
            {MOST_POS,    MOST_NEG,    1'b1, 1'b1, NEG_ONE,  1'b0},
            {16'h0000,    MOST_NEG,    1'b1, 1'b1, 16'h0000, 1'b1},  // a is all zero
            {16'hFFFF,    16'h0000,    1'b1, 1'b1, 16'h0000, 1'b1},  // b is all zero
            {16'h0001,    16'h0000,    1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0000,    16'h0001,    1'b1, 1'b1, 16'h0000, 1'b0},  // orthogonal
            {16'd3,       16'd4,       1'b0, 1'b0, 16'h0000, 1'b0},
            {16'd4,       16'd3,       1'b1, 1'b0, 16'h0000, 1'b0},
            {16'd1000,   -16'sd2000,   1'b0, 1'b0, 16'h0000, 1'b0},
            {-16'sd3000,  16'd500,     1'b0, 1'b0, 16'h0000, 1'b0},
            {16'd7,      -16'sd9,      1'b1, 1'b0, 16'h0000, 1'b0},
            {16'hFFFF,    16'hFFFF,    1'b1, 1'b1, POS_ONE,  1'b0},
            {16'hFFFF,    MOST_POS,    1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0001,    MOST_NEG,    1'b1, 1'b0, 16'h0000, 1'b0},
            // cosine exactly -32767/32768: half-way tie, rounds away from zero
            {16'hFFFF,    MOST_POS,    1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0000,    16'd255,     1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0000,    16'd22,      1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0000,    16'd5,       1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0000,    16'd1,       1'b1, 1'b1, NEG_ONE,  1'b0},
            {16'd12345,  -16'sd23456,  1'b0, 1'b0, 16'h0000, 1'b0},
            {-16'sd21846, 16'd9999,    1'b1, 1'b0, 16'h0000, 1'b0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows
        for (int i = 0; i < DIR_ROWS; i++)
            send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                      dir_rows[i].known, dir_rows[i].want);

        // Long vector at full scale, items back to back
        tx_gaps_on = 1'b0;
        for (int i = 0; i < FULL_PAIRS; i++)
        begin
            ext_a = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
            ext_b = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
            send_pair(ext_a, ext_b, i == FULL_PAIRS - 1, 1'b0, '0);
        end

        // Random vectors, mostly short, under changing idle patterns
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            tx_gaps_on   = ($urandom_range(0, 4) != 0);
            rx_stalls_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 95)
                len = $urandom_range(7, 64);
            else
                len = $urandom_range(65, 400);
            r = $urandom_range(0, 99);
            if (r < 55)
                send_vector(len, 0);
            else if (r < 65)
                send_vector(len, 1);
            else if (r < 75)
                send_vector(len, 2);
            else if (r < 80)
                send_vector(len, 3);
            else if (r < 85)
                send_vector(len, 4);
            else
                send_vector(len, 5);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Wait until every result due has been seen, then run on before the summary
        while (similarity_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("%0d pairs sent, %0d results checked (%0d zero norm, %0d at plus or minus one)",
                 items_sent, results_seen, zero_norm_seen, full_scale_seen);
        $display("included directed corner rows and a %0d-pair full-scale vector",
                 FULL_PAIRS);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("%0t: timeout, %0d results still due", $time, similarity_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
